[design/lowq_pkg.sv]
// Shared types and codes for the ordered wait queue block.
package lowq_pkg;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_CANCEL  = 2'd1,
    ACT_ACK     = 2'd2,
    ACT_WAKE    = 2'd3
  } action_t;

  // Result outcomes.
  typedef enum logic [1:0] {
    OUT_RELEASED  = 2'd0,
    OUT_NO_WAIT   = 2'd1,
    OUT_CANCELLED = 2'd2,
    OUT_REJECTED  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  waiter_id;
    logic        wait_mode;
    logic [63:0] wait_position;
    logic [63:0] ack_write_position;
    logic [63:0] ack_flush_position;
  } in_item_t;

  typedef struct packed {
    logic [5:0] done_id;
    logic [1:0] outcome;
    logic       last;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [63:0] position;
    logic [5:0]  waiter;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACK_CHK,
    ST_INS_RD,
    ST_INS_CHK,
    ST_CAN_RD,
    ST_CAN_CHK,
    ST_CAN_FIN,
    ST_REL_RD,
    ST_REL_CHK,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     idle;
    logic     load;
    logic     set_q;
    logic     q_val;
    logic     at_init;
    logic     rd_ins;
    logic     rd_can;
    logic     rd_rel;
    logic     ins_shift;
    logic     ins_place;
    logic     can_keep;
    logic     can_step;
    logic     can_restart;
    logic     can_end;
    logic     rel_pop;
    logic     wm_set;
    logic     emit;
    outcome_t emit_code;
    logic     flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    id_bad;
    logic    no_wait;
    logic    full;
    logic    idx_zero;
    logic    ins_ge;
    logic    r_end;
    logic    keep;
    logic    cnt_zero;
    logic    rel_take;
    logic    ackf_zero;
    logic    grow;
    logic    found;
    logic    q;
    logic    out_free;
    logic    held_valid;
  } sts_t;

endpackage

[design/lowq_ctrl.sv]
// Sequencing state machine for the ordered wait queue block.
module lowq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lowq_pkg::sts_t sts,
  output lowq_pkg::cmd_t cmd
);

  lowq_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lowq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state. Nothing advances past idle while the output register is blocked.
  always_comb begin
    state_next = state;
    if (state == lowq_pkg::ST_IDLE) begin
      if (in_valid) state_next = lowq_pkg::ST_DISPATCH;
    end else if (sts.out_free) begin
      case (state)
        lowq_pkg::ST_DISPATCH: begin
          case (sts.action)
            lowq_pkg::ACT_ENQUEUE: begin
              if (sts.id_bad || sts.no_wait || sts.full) state_next = lowq_pkg::ST_FIN;
              else state_next = lowq_pkg::ST_INS_RD;
            end
            lowq_pkg::ACT_CANCEL: state_next = lowq_pkg::ST_CAN_RD;
            lowq_pkg::ACT_ACK: begin
              state_next = sts.ackf_zero ? lowq_pkg::ST_FIN : lowq_pkg::ST_ACK_CHK;
            end
            default: state_next = lowq_pkg::ST_REL_RD;
          endcase
        end
        lowq_pkg::ST_ACK_CHK: begin
          if (sts.grow) state_next = lowq_pkg::ST_REL_RD;
          else if (sts.q) state_next = lowq_pkg::ST_FIN;
        end
        lowq_pkg::ST_INS_RD: begin
          state_next = sts.idx_zero ? lowq_pkg::ST_FIN : lowq_pkg::ST_INS_CHK;
        end
        lowq_pkg::ST_INS_CHK: begin
          state_next = sts.ins_ge ? lowq_pkg::ST_INS_RD : lowq_pkg::ST_FIN;
        end
        lowq_pkg::ST_CAN_RD: begin
          if (!sts.r_end) state_next = lowq_pkg::ST_CAN_CHK;
          else if (sts.q) state_next = lowq_pkg::ST_CAN_FIN;
        end
        lowq_pkg::ST_CAN_CHK: state_next = lowq_pkg::ST_CAN_RD;
        lowq_pkg::ST_CAN_FIN: state_next = lowq_pkg::ST_FIN;
        lowq_pkg::ST_REL_RD, lowq_pkg::ST_REL_CHK: begin
          if ((state == lowq_pkg::ST_REL_RD && !sts.cnt_zero) ||
              (state == lowq_pkg::ST_REL_CHK && sts.rel_take)) begin
            state_next = (state == lowq_pkg::ST_REL_RD) ? lowq_pkg::ST_REL_CHK
                                                        : lowq_pkg::ST_REL_RD;
          end else if (sts.q) begin
            state_next = lowq_pkg::ST_FIN;
          end else if (sts.action == lowq_pkg::ACT_ACK) begin
            state_next = lowq_pkg::ST_ACK_CHK;
          end else begin
            state_next = lowq_pkg::ST_REL_RD;
          end
        end
        lowq_pkg::ST_FIN: state_next = lowq_pkg::ST_IDLE;
        default: state_next = lowq_pkg::ST_IDLE;
      endcase
    end
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    cmd.emit_code = lowq_pkg::OUT_RELEASED;
    if (state == lowq_pkg::ST_IDLE) begin
      cmd.idle = 1'b1;
      cmd.load = in_valid;
    end else if (sts.out_free) begin
      case (state)
        lowq_pkg::ST_DISPATCH: begin
          case (sts.action)
            lowq_pkg::ACT_ENQUEUE: begin
              if (sts.id_bad) begin
                cmd.emit = 1'b1;
                cmd.emit_code = lowq_pkg::OUT_REJECTED;
              end else if (sts.no_wait) begin
                cmd.emit = 1'b1;
                cmd.emit_code = lowq_pkg::OUT_NO_WAIT;
              end else if (sts.full) begin
                cmd.emit = 1'b1;
                cmd.emit_code = lowq_pkg::OUT_REJECTED;
              end else begin
                cmd.set_q = 1'b1;
                cmd.q_val = 1'b0;
                cmd.at_init = 1'b1;
              end
            end
            lowq_pkg::ACT_CANCEL: begin
              cmd.set_q = 1'b1;
              cmd.can_restart = 1'b1;
            end
            default: cmd.set_q = 1'b1;
          endcase
        end
        lowq_pkg::ST_ACK_CHK: begin
          if (sts.grow) begin
            cmd.wm_set = 1'b1;
          end else if (!sts.q) begin
            cmd.set_q = 1'b1;
            cmd.q_val = 1'b1;
          end
        end
        lowq_pkg::ST_INS_RD: begin
          if (sts.idx_zero) cmd.ins_place = 1'b1;
          else cmd.rd_ins = 1'b1;
        end
        lowq_pkg::ST_INS_CHK: begin
          if (sts.ins_ge) cmd.ins_shift = 1'b1;
          else cmd.ins_place = 1'b1;
        end
        lowq_pkg::ST_CAN_RD: begin
          if (!sts.r_end) begin
            cmd.rd_can = 1'b1;
          end else begin
            cmd.can_end = 1'b1;
            if (!sts.q) begin
              cmd.set_q = 1'b1;
              cmd.q_val = 1'b1;
              cmd.can_restart = 1'b1;
            end
          end
        end
        lowq_pkg::ST_CAN_CHK: begin
          cmd.can_keep = sts.keep;
          cmd.can_step = 1'b1;
        end
        lowq_pkg::ST_CAN_FIN: begin
          cmd.emit = sts.found;
          cmd.emit_code = lowq_pkg::OUT_CANCELLED;
        end
        lowq_pkg::ST_REL_RD, lowq_pkg::ST_REL_CHK: begin
          if (state == lowq_pkg::ST_REL_RD && !sts.cnt_zero) begin
            cmd.rd_rel = 1'b1;
          end else if (state == lowq_pkg::ST_REL_CHK && sts.rel_take) begin
            cmd.rel_pop = 1'b1;
          end else if (!sts.q) begin
            cmd.set_q = 1'b1;
            cmd.q_val = 1'b1;
          end
        end
        lowq_pkg::ST_FIN: cmd.flush = sts.held_valid;
        default: cmd = '0;
      endcase
    end
  end

endmodule

[design/lowq_dp.sv]
// Datapath of the ordered wait queue block: entry memory, counters and result registers.
module lowq_dp #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int WAITER_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  lowq_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  lowq_pkg::cmd_t      cmd,
  output lowq_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output lowq_pkg::out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int AW = $clog2(2 * QUEUE_DEPTH);

  lowq_pkg::entry_t mem [2 * QUEUE_DEPTH];

  lowq_pkg::in_item_t  in_r;
  lowq_pkg::entry_t    rdata;
  lowq_pkg::out_item_t held;
  logic                held_valid;
  logic                q;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       wr;
  logic [CW-1:0]       cnt [2];
  logic [IW-1:0]       head [2];
  logic [63:0]         wm [2];
  logic                found;
  logic                sync_en;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  lowq_pkg::entry_t    wr_data;
  logic                emit_any;
  lowq_pkg::out_item_t emit_val;
  logic [CW-1:0]       idx_dec;

  // Slot of the k-th entry from the head, wrapped within the queue.
  function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[IW-1:0];
  endfunction

  // Memory address of a slot in queue m.
  function automatic logic [AW-1:0] phys(input logic m, input logic [IW-1:0] k);
    logic [AW-1:0] base;
    base = m ? AW'(QUEUE_DEPTH) : '0;
    return base + AW'(k);
  endfunction

  assign idx_dec = idx - CW'(1);

  // Memory port selection.
  always_comb begin
    rd_en   = cmd.rd_ins | cmd.rd_can | cmd.rd_rel;
    rd_addr = phys(q, head[q]);
    if (cmd.rd_ins) rd_addr = phys(q, wrap_idx(head[q], idx_dec));
    else if (cmd.rd_can) rd_addr = phys(q, wrap_idx(head[q], idx));
    wr_en   = cmd.ins_shift | cmd.ins_place | cmd.can_keep;
    wr_addr = cmd.can_keep ? phys(q, wrap_idx(head[q], wr)) : phys(q, wrap_idx(head[q], idx));
    wr_data = rdata;
    if (cmd.ins_place) wr_data = '{position: in_r.wait_position, waiter: in_r.waiter_id};
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // The result that a step produces now.
  always_comb begin
    emit_any = cmd.emit | cmd.rel_pop;
    emit_val.done_id = cmd.rel_pop ? rdata.waiter : in_r.waiter_id;
    emit_val.outcome = cmd.rel_pop ? lowq_pkg::OUT_RELEASED : cmd.emit_code;
    emit_val.last    = 1'b0;
  end

  // Payload registers. An insert works on the queue that the item names.
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_item;
    if (cmd.set_q) q <= cmd.at_init ? in_r.wait_mode : cmd.q_val;
    if (cmd.at_init) idx <= cnt[in_r.wait_mode];
    if (cmd.can_restart) begin
      idx <= '0;
      wr  <= '0;
    end
    if (cmd.ins_shift) idx <= idx_dec;
    if (cmd.can_step) idx <= idx + CW'(1);
    if (cmd.can_keep) wr <= wr + CW'(1);
    if (emit_any) held <= emit_val;
    if (emit_any && held_valid) out_item <= held;
    if (cmd.flush) out_item <= '{done_id: held.done_id, outcome: held.outcome, last: 1'b1};
  end

  // Control state: counts, heads, watermarks and handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '{default: '0};
      head       <= '{default: '0};
      wm         <= '{default: '0};
      sync_en    <= 1'b0;
      found      <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) sync_en <= cfg_data;
      if (cmd.load) found <= 1'b0;
      if (cmd.can_end) begin
        cnt[q] <= wr;
        if (wr != cnt[q]) found <= 1'b1;
      end
      if (cmd.ins_place) cnt[q] <= cnt[q] + CW'(1);
      if (cmd.rel_pop) begin
        cnt[q]  <= cnt[q] - CW'(1);
        head[q] <= wrap_idx(head[q], CW'(1));
      end
      if (cmd.wm_set) wm[q] <= q ? in_r.ack_flush_position : in_r.ack_write_position;
      if (emit_any) held_valid <= 1'b1;
      else if (cmd.flush) held_valid <= 1'b0;
      if ((emit_any && held_valid) || cmd.flush) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.action     = lowq_pkg::action_t'(in_r.action);
    sts.id_bad     = 32'(in_r.waiter_id) >= WAITER_COUNT;
    sts.no_wait    = !sync_en || (in_r.wait_position <= wm[in_r.wait_mode]);
    sts.full       = cnt[in_r.wait_mode] >= CW'(QUEUE_DEPTH);
    sts.idx_zero   = idx == '0;
    sts.ins_ge     = rdata.position >= in_r.wait_position;
    sts.r_end      = idx == cnt[q];
    sts.keep       = rdata.waiter != in_r.waiter_id;
    sts.cnt_zero   = cnt[q] == '0;
    sts.rel_take   = (in_r.action == lowq_pkg::ACT_WAKE) || (rdata.position <= wm[q]);
    sts.ackf_zero  = in_r.ack_flush_position == '0;
    sts.grow       = q ? (wm[1] < in_r.ack_flush_position) : (wm[0] < in_r.ack_write_position);
    sts.found      = found;
    sts.q          = q;
    sts.out_free   = !out_valid || !out_stall;
    sts.held_valid = held_valid;
  end

  // Counts never pass the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CW'(QUEUE_DEPTH) && cnt[1] <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // An insert only lands in a queue that has room.
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |-> cnt[q] < CW'(QUEUE_DEPTH))
    else $error("insert into full queue");

  // A release pops only from a non-empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rel_pop |-> cnt[q] != '0)
    else $error("release from empty queue");

  // A flush presents the held result on the output, marked last.
  a_flush_held: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> out_valid && out_item.last)
    else $error("final result not presented");

endmodule

[design/lsn_ordered_wait_queue_core.sv]
// Top level of the ordered wait queue block.
// Keeps a write-ack and a flush-ack wait queue sorted by 64-bit log position, plus
// two acknowledged watermarks. One item is handled at a time: after dispatch, a sorted
// insert steps once per entry it moves past, a cancel steps through every entry of
// both queues, and an acknowledge or wake-all steps once per entry examined; every
// entry step is one read of the single-ported entry memory followed by a compare.
// Results leave through a one-entry output register; the last result of an item
// carries last set, and a blocked output pauses the walk.
module lsn_ordered_wait_queue_core #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int WAITER_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lowq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lowq_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  lowq_pkg::cmd_t cmd;
  lowq_pkg::sts_t sts;

  assign in_stall  = !cmd.idle;
  assign cfg_ready = cmd.idle;

  lowq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  lowq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .WAITER_COUNT (WAITER_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cmd.idle),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[dv/tb_lsn_ordered_wait_queue_core.sv]
// Self-checking testbench for the ordered wait queue block: random and directed items.
`timescale 1ns / 100ps

module tb_lsn_ordered_wait_queue_core;

  localparam int QUEUE_DEPTH  = 32;
  localparam int WAITER_COUNT = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 300;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  lowq_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  lowq_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  lsn_ordered_wait_queue_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WAITER_COUNT(WAITER_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Shadow of the block state used to predict results.
  lowq_pkg::entry_t waiters [2][$];
  logic [63:0]      acked_pos [2] = '{64'd0, 64'd0};
  logic             sync_on = 1'b0;

  lowq_pkg::in_item_t  pending_items [$];
  lowq_pkg::out_item_t expected_results [$];
  logic [63:0] lsn_head;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count = 0;
  int          items_sent = 0;
  int          items_driven = 0;
  int          results_seen = 0;
  int          cycle_count = 0;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Append one result to the expected list.
  function automatic void expect_result(logic [5:0] id, lowq_pkg::outcome_t code);
    lowq_pkg::out_item_t r;
    r.done_id = id;
    r.outcome = code;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Release waiters from the head of queue m, or all of them when drain is set.
  function automatic void release_waiters(int m, bit drain);
    while (waiters[m].size() > 0 && (drain || waiters[m][0].position <= acked_pos[m])) begin
      expect_result(waiters[m][0].waiter, lowq_pkg::OUT_RELEASED);
      void'(waiters[m].pop_front());
    end
  endfunction

  // Remove every entry of the given waiter from queue m; report whether any matched.
  function automatic bit drop_waiter(int m, logic [5:0] id);
    lowq_pkg::entry_t kept [$];
    bit hit;
    hit = 1'b0;
    foreach (waiters[m][i]) begin
      if (waiters[m][i].waiter == id) hit = 1'b1;
      else kept.push_back(waiters[m][i]);
    end
    waiters[m] = kept;
    return hit;
  endfunction

  // Work out the results of one accepted item and update the shadow state.
  function automatic void predict_wait_queue(lowq_pkg::in_item_t it);
    int prior_count;
    int at;
    int m;
    bit hit0;
    bit hit1;
    lowq_pkg::entry_t e;
    prior_count = expected_results.size();
    m = it.wait_mode;
    case (lowq_pkg::action_t'(it.action))
      lowq_pkg::ACT_ENQUEUE: begin
        if (!sync_on || it.wait_position <= acked_pos[m]) begin
          expect_result(it.waiter_id, lowq_pkg::OUT_NO_WAIT);
        end else if (waiters[m].size() >= QUEUE_DEPTH) begin
          expect_result(it.waiter_id, lowq_pkg::OUT_REJECTED);
        end else begin
          // A new waiter goes ahead of equal positions.
          at = waiters[m].size();
          while (at > 0 && waiters[m][at-1].position >= it.wait_position) at--;
          e.position = it.wait_position;
          e.waiter = it.waiter_id;
          waiters[m].insert(at, e);
        end
      end
      lowq_pkg::ACT_CANCEL: begin
        hit0 = drop_waiter(0, it.waiter_id);
        hit1 = drop_waiter(1, it.waiter_id);
        if (hit0 || hit1) expect_result(it.waiter_id, lowq_pkg::OUT_CANCELLED);
      end
      lowq_pkg::ACT_ACK: begin
        // A zero flush position voids the whole acknowledge.
        if (it.ack_flush_position != 64'd0) begin
          if (acked_pos[0] < it.ack_write_position) begin
            acked_pos[0] = it.ack_write_position;
            release_waiters(0, 1'b0);
          end
          if (acked_pos[1] < it.ack_flush_position) begin
            acked_pos[1] = it.ack_flush_position;
            release_waiters(1, 1'b0);
          end
        end
      end
      default: begin
        release_waiters(0, 1'b1);
        release_waiters(1, 1'b1);
      end
    endcase
    if (expected_results.size() > prior_count)
      expected_results[expected_results.size()-1].last = 1'b1;
  endfunction

  // Queue one item for the driver.
  function automatic void add_item(lowq_pkg::action_t a, logic [5:0] id, logic mode,
                                   logic [63:0] wpos, logic [63:0] aw, logic [63:0] af);
    lowq_pkg::in_item_t it;
    it.action = a;
    it.waiter_id = id;
    it.wait_mode = mode;
    it.wait_position = wpos;
    it.ack_write_position = aw;
    it.ack_flush_position = af;
    pending_items.push_back(it);
  endfunction

  // Waiter ids mostly from a small set so duplicates and cancel hits are common.
  function automatic logic [5:0] pick_id();
    return ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed traffic around a rising log head, with some noise.
  function automatic void add_random_item();
    int r;
    logic [63:0] af;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      add_item(lowq_pkg::action_t'($urandom_range(0, 3)), 6'($urandom), 1'($urandom),
               {$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
      if (pending_items[$].action != lowq_pkg::ACT_ACK)
        pending_items[$].ack_flush_position = {$urandom, $urandom};
    end else if (r < 56) begin
      add_item(lowq_pkg::ACT_ENQUEUE, pick_id(), 1'($urandom),
               lsn_head + $urandom_range(1, 64), 64'd0, 64'd0);
    end else if (r < 70) begin
      add_item(lowq_pkg::ACT_CANCEL, pick_id(), 1'b0, 64'd0, 64'd0, 64'd0);
    end else if (r < 96) begin
      af = ($urandom_range(0, 9) == 0) ? 64'd0 : lsn_head + $urandom_range(1, 40);
      add_item(lowq_pkg::ACT_ACK, 6'd0, 1'b0, 64'd0, lsn_head + $urandom_range(0, 40), af);
      lsn_head = lsn_head + $urandom_range(0, 30);
    end else begin
      add_item(lowq_pkg::ACT_WAKE, 6'd0, 1'b0, 64'd0, 64'd0, 64'd0);
    end
  endfunction

  // Wait until every item is in and every expected result is out, then let it settle.
  task automatic drain_block();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the sync enable register while the block is idle.
  task automatic write_sync(logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sync_on = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input side: accept at the rising edge and predict.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_wait_queue(in_item);
      items_sent++;
    end
  end

  // Drive the next item at the falling edge once the current one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || items_sent == items_driven) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        items_driven++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stall, then compare each accepted result with the oldest expectation.
  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    lowq_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: done_id %0d outcome %0d last %0d",
               out_item.done_id, out_item.outcome, out_item.last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.done_id !== want.done_id) begin
          $error("done_id: expected %0d, got %0d", want.done_id, out_item.done_id);
          fail_count++;
        end
        if (out_item.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_item.outcome);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    lsn_head = 64'd10;
    send_idle_pct = 8;
    recv_idle_pct = 58;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_sync(1'b1);

    // Directed: ordering of equal positions, ignored and stale acks, cancel, wake-all.
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd0, 1'b0, 64'd5, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd63, 1'b1, 64'd5, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd1, 1'b0, 64'd5, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd2, 1'b0, 64'd3, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd2, 1'b1, 64'd9, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd3, 1'b0, '1, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ACK, 6'd0, 1'b0, 64'd0, 64'd4, 64'd0);
    add_item(lowq_pkg::ACT_ACK, 6'd0, 1'b0, 64'd0, 64'd5, 64'd5);
    add_item(lowq_pkg::ACT_ACK, 6'd0, 1'b0, 64'd0, 64'd5, 64'd5);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd4, 1'b0, 64'd5, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_CANCEL, 6'd2, 1'b0, 64'd0, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_CANCEL, 6'd9, 1'b0, 64'd0, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_WAKE, 6'd0, 1'b0, 64'd0, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd5, 1'b1, 64'd7, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd6, 1'b0, 64'd20, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_WAKE, 6'd0, 1'b0, 64'd0, 64'd0, 64'd0);
    repeat (90) add_random_item();
    drain_block();

    // With sync off every enqueue completes at once.
    write_sync(1'b0);
    repeat (25) add_random_item();
    drain_block();
    write_sync(1'b1);

    send_idle_pct = 58;
    recv_idle_pct = 8;
    repeat (80) add_random_item();
    drain_block();

    // No idling: fill the write queue past its depth, then random traffic and
    // finally acknowledge everything at the top of the position range.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (34) add_item(lowq_pkg::ACT_ENQUEUE, pick_id(), 1'b0,
                         lsn_head + $urandom_range(1, 500), 64'd0, 64'd0);
    repeat (40) add_random_item();
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd62, 1'b1, '1, 64'd0, 64'd0);
    add_item(lowq_pkg::ACT_ACK, 6'd0, 1'b0, 64'd0, '1, '1);
    add_item(lowq_pkg::ACT_ENQUEUE, 6'd61, 1'b0, '1, 64'd0, 64'd0);
    drain_block();

    $display("Covered %0d items and %0d results over sync on and off,", items_sent, results_seen);
    $display("including full-queue rejects, cancels, wake-all and top-of-range acks.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
